[hdl/rmcp_pkg.sv]
// Shared types, constants and helper functions of the RMC sentence parser.
`default_nettype none
package rmcp_pkg;

  localparam int FRAC_W   = 20;
  localparam int IPART_W  = 17;
  localparam int PD_W     = 35;
  localparam int X_W      = 27;
  localparam int DEGM_W   = 30;
  localparam int P_W      = 54;
  localparam int MICRO_W  = 31;
  localparam int LAT_W    = 28;
  localparam int LON_W    = 29;
  localparam int RES_W    = 104;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;

  localparam logic [3:0] FLD_TIME   = 4'd1;
  localparam logic [3:0] FLD_STATUS = 4'd2;
  localparam logic [3:0] FLD_LAT    = 4'd3;
  localparam logic [3:0] FLD_NS     = 4'd4;
  localparam logic [3:0] FLD_LON    = 4'd5;
  localparam logic [3:0] FLD_EW     = 4'd6;
  localparam logic [3:0] FLD_DATE   = 4'd9;
  localparam logic [3:0] FLD_LAST   = 4'd15;

  localparam logic [0:0] CFG_ZONE_HOURS   = 1'b0;
  localparam logic [0:0] CFG_ZONE_MINUTES = 1'b1;
  localparam logic [4:0] ZONE_HOURS_RST   = 5'd5;
  localparam logic [5:0] ZONE_MINUTES_RST = 6'd30;

  localparam logic [IPART_W-1:0] IPART_MAX = 17'd99999;
  localparam logic [17:0]        DIV100_M  = 18'd167772;
  localparam logic [26:0]        DIV60_M   = 27'd71582788;
  localparam logic [MICRO_W-1:0] LAT_LIM   = 31'd90000000;
  localparam logic [MICRO_W-1:0] LON_LIM   = 31'd180000000;
  localparam logic [11:0]        YEAR_BASE = 12'd2000;

  typedef struct packed {
    logic [IPART_W-1:0] ipart;
    logic [FRAC_W-1:0]  frac;
    logic [2:0]         fcount;
    logic               dot;
    logic               stop;
  } coord_t;

  typedef struct packed {
    logic                time_ok;
    logic [5:0][3:0]     tdig;
    logic                status;
    logic                date_ok;
    logic [5:0][3:0]     ddig;
    logic [1:0]          hemi;
    coord_t [1:0]        crd;
  } line_rec_t;

  typedef struct packed {
    logic      push;
    line_rec_t rec;
  } fifo_wr_t;

  typedef struct packed {
    logic       busy;
    logic       emit;
  } bk_status_t;

  typedef struct packed {
    logic                    fix_valid;
    logic [4:0]              hour;
    logic [5:0]              minute;
    logic [5:0]              second;
    logic [5:0]              day;
    logic [3:0]              month;
    logic [11:0]             year;
    logic signed [LAT_W-1:0] latitude;
    logic signed [LON_W-1:0] longitude;
  } rmc_result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_SPLIT,
    BK_SCALE,
    BK_RECIP,
    BK_EMIT
  } bk_state_e;

  function automatic logic [FRAC_W-1:0] pow10(input logic [2:0] n);
    logic [FRAC_W-1:0] r;
    r = '0;
    case (n)
      3'd0: r = 20'd1;
      3'd1: r = 20'd10;
      3'd2: r = 20'd100;
      3'd3: r = 20'd1000;
      3'd4: r = 20'd10000;
      3'd5: r = 20'd100000;
      3'd6: r = 20'd1000000;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] r;
    r = 8'h00;
    case (idx)
      3'd0: r = 8'h24;
      3'd1: r = 8'h47;
      3'd2: r = 8'h50;
      3'd3: r = 8'h52;
      3'd4: r = 8'h4D;
      3'd5: r = 8'h43;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic coord_t coord_feed(input coord_t a, input logic [7:0] c,
                                        input logic [2:0] fd);
    coord_t      r;
    logic [20:0] ip;
    logic [23:0] fr;
    r  = a;
    ip = '0;
    fr = '0;
    if (!a.stop) begin
      if (is_digit(c)) begin
        if (!a.dot) begin
          ip = 21'(a.ipart) * 21'd10 + 21'(c[3:0]);
          r.ipart = (ip > 21'(IPART_MAX)) ? IPART_MAX : ip[IPART_W-1:0];
        end else if (a.fcount < fd) begin
          fr = 24'(a.frac) * 24'd10 + 24'(c[3:0]);
          r.frac = fr[FRAC_W-1:0];
          r.fcount = a.fcount + 3'd1;
        end
      end else if (c == CH_DOT && !a.dot) begin
        r.dot = 1'b1;
      end else begin
        r.stop = 1'b1;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/rmcp_front.sv]
// Byte front end: tracks line, header and field position and gathers field values.
`default_nettype none
module rmcp_front
  import rmcp_pkg::*;
#(
  parameter int LINE_LIMIT      = 128,
  parameter int FRACTION_DIGITS = 5
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  output logic       byte_ready_o,
  input  logic       full_i,
  output fifo_wr_t   wr_o
);

  localparam int LC_W = $clog2(LINE_LIMIT);
  localparam logic [LC_W-1:0] LC_STOP = LC_W'(LINE_LIMIT - 1);
  localparam logic [2:0]      FD      = 3'(FRACTION_DIGITS);

  logic [LC_W-1:0] line_count_q, line_count_d;
  logic [3:0]      field_number_q, field_number_d;
  logic [3:0]      field_char_q, field_char_d;
  logic [2:0]      hdr_prog_q, hdr_prog_d;
  logic            hdr_seen_q, hdr_seen_d;
  logic            status_q, status_d;
  logic            time_ok_q, time_ok_d;
  logic            date_ok_q, date_ok_d;
  logic [5:0][3:0] tdig_q, tdig_d;
  logic [5:0][3:0] ddig_q, ddig_d;
  logic [1:0]      hemi_q, hemi_d;
  coord_t [1:0]    crd_q, crd_d;

  logic       accept;
  logic       time_ok_fin;
  logic       date_ok_fin;
  logic [3:0] digit;

  assign byte_ready_o = !full_i;
  assign accept       = byte_valid_i && byte_ready_o;
  assign digit        = is_digit(byte_i) ? byte_i[3:0] : 4'd0;
  assign time_ok_fin  = (field_number_q == FLD_TIME) ? (field_char_q >= 4'd6) : time_ok_q;
  assign date_ok_fin  = (field_number_q == FLD_DATE) ? (field_char_q == 4'd6) : date_ok_q;

  always_comb begin
    wr_o.push         = accept && (byte_i == CH_LF) && hdr_seen_q;
    wr_o.rec.time_ok  = time_ok_fin;
    wr_o.rec.tdig     = tdig_q;
    wr_o.rec.status   = status_q;
    wr_o.rec.date_ok  = date_ok_fin;
    wr_o.rec.ddig     = ddig_q;
    wr_o.rec.hemi     = hemi_q;
    wr_o.rec.crd      = crd_q;
  end

  always_comb begin
    line_count_d   = line_count_q;
    field_number_d = field_number_q;
    field_char_d   = field_char_q;
    hdr_prog_d     = hdr_prog_q;
    hdr_seen_d     = hdr_seen_q;
    status_d       = status_q;
    time_ok_d      = time_ok_q;
    date_ok_d      = date_ok_q;
    tdig_d         = tdig_q;
    ddig_d         = ddig_q;
    hemi_d         = hemi_q;
    crd_d          = crd_q;
    if (accept) begin
      if (byte_i == CH_LF) begin
        line_count_d   = '0;
        field_number_d = '0;
        field_char_d   = '0;
        hdr_prog_d     = '0;
        hdr_seen_d     = 1'b0;
        status_d       = 1'b0;
        time_ok_d      = 1'b0;
        date_ok_d      = 1'b0;
        tdig_d         = '0;
        ddig_d         = '0;
        hemi_d         = '0;
        crd_d          = '0;
      end else if (line_count_q < LC_STOP) begin
        line_count_d = line_count_q + LC_W'(1);
        if ((line_count_q < LC_W'(6)) && (LC_W'(hdr_prog_q) == line_count_q) &&
            (byte_i == hdr_char(line_count_q[2:0]))) begin
          hdr_prog_d = hdr_prog_q + 3'd1;
          if (hdr_prog_q == 3'd5) begin
            hdr_seen_d = 1'b1;
          end
        end
        if (byte_i == CH_COMMA) begin
          time_ok_d    = time_ok_fin;
          date_ok_d    = date_ok_fin;
          field_char_d = '0;
          if (field_number_q < FLD_LAST) begin
            field_number_d = field_number_q + 4'd1;
          end
        end else begin
          case (field_number_q)
            FLD_TIME: begin
              if (field_char_q < 4'd6) begin
                tdig_d[field_char_q[2:0]] = digit;
              end
            end
            FLD_STATUS: begin
              if (field_char_q == 4'd0) begin
                status_d = (byte_i == CH_A);
              end
            end
            FLD_LAT: crd_d[0] = coord_feed(crd_q[0], byte_i, FD);
            FLD_NS: begin
              if (field_char_q == 4'd0 && byte_i == CH_S) begin
                hemi_d[0] = 1'b1;
              end
            end
            FLD_LON: crd_d[1] = coord_feed(crd_q[1], byte_i, FD);
            FLD_EW: begin
              if (field_char_q == 4'd0 && byte_i == CH_W) begin
                hemi_d[1] = 1'b1;
              end
            end
            FLD_DATE: begin
              if (field_char_q < 4'd6) begin
                ddig_d[field_char_q[2:0]] = digit;
              end
            end
            default: ;
          endcase
          if (field_char_q < FLD_LAST) begin
            field_char_d = field_char_q + 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q   <= '0;
      field_number_q <= '0;
      field_char_q   <= '0;
      hdr_prog_q     <= '0;
      hdr_seen_q     <= 1'b0;
      status_q       <= 1'b0;
      time_ok_q      <= 1'b0;
      date_ok_q      <= 1'b0;
      tdig_q         <= '0;
      ddig_q         <= '0;
      hemi_q         <= '0;
      crd_q          <= '0;
    end else begin
      line_count_q   <= line_count_d;
      field_number_q <= field_number_d;
      field_char_q   <= field_char_d;
      hdr_prog_q     <= hdr_prog_d;
      hdr_seen_q     <= hdr_seen_d;
      status_q       <= status_d;
      time_ok_q      <= time_ok_d;
      date_ok_q      <= date_ok_d;
      tdig_q         <= tdig_d;
      ddig_q         <= ddig_d;
      hemi_q         <= hemi_d;
      crd_q          <= crd_d;
    end
  end

endmodule
`default_nettype wire

[hdl/rmcp_fifo.sv]
// Two-entry queue of finished line records between front end and back end.
`default_nettype none
module rmcp_fifo
  import rmcp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  fifo_wr_t  wr_i,
  input  logic      pop_i,
  output line_rec_t rec_o,
  output logic      empty_o,
  output logic      full_o
);

  line_rec_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign rec_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      mem_q[wr_ptr_q] <= wr_i.rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (wr_i.push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(wr_i.push) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

[hdl/rmcp_back.sv]
// Back end: coordinate conversion steps, held values, zone offset and output register.
`default_nettype none
module rmcp_back
  import rmcp_pkg::*;
#(
  parameter int FRACTION_DIGITS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [4:0]  zone_hours_i,
  input  logic [5:0]  zone_minutes_i,
  input  logic        empty_i,
  input  line_rec_t   rec_i,
  output logic        pop_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output rmc_result_t out_o,
  output bk_status_t  stat_o
);

  localparam logic [2:0]        FD      = 3'(FRACTION_DIGITS);
  localparam logic [FRAC_W-1:0] SCALE_K = pow10(3'(6 - FRACTION_DIGITS));

  bk_state_e state_q, state_d;

  line_rec_t            rec_q;
  logic [PD_W-1:0]      pd_q   [2];
  logic [FRAC_W-1:0]    fsc_q  [2];
  logic [9:0]           deg_q  [2];
  logic [6:0]           mm_q   [2];
  logic [X_W-1:0]       x_q    [2];
  logic [DEGM_W-1:0]    degm_q [2];
  logic [P_W-1:0]       p_q    [2];

  logic [4:0]  hh_q;
  logic [5:0]  hm_q, hs_q, hd_q;
  logic [3:0]  hmo_q;
  logic [6:0]  hyy_q;
  logic signed [LAT_W-1:0] hlat_q;
  logic signed [LON_W-1:0] hlon_q;

  logic        out_valid_q;
  rmc_result_t out_q;

  logic out_free;
  logic emit;

  logic [10:0] qe100 [2];
  logic [17:0] r100  [2];
  logic [2*FRAC_W-1:0] fprod [2];
  logic [21:0]  qe60  [2];
  logic [27:0]  r60   [2];
  logic [21:0]  q60   [2];
  logic [MICRO_W-1:0] micro [2];
  logic [MICRO_W-1:0] msat  [2];
  logic [LON_W-1:0]   sval  [2];

  logic [6:0]  t_h, t_m, t_s, d_d, d_mo, d_yy;
  logic [4:0]  n_h;
  logic [5:0]  n_m, n_s, n_d;
  logic [3:0]  n_mo;
  logic [6:0]  n_yy;
  logic [4:0]  zh;
  logic [5:0]  zm;
  logic [5:0]  hsum;
  logic [6:0]  msum;
  logic [5:0]  dsum;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (!empty_i) state_d = BK_DIV;
      BK_DIV:   state_d = BK_SPLIT;
      BK_SPLIT: state_d = BK_SCALE;
      BK_SCALE: state_d = BK_RECIP;
      BK_RECIP: state_d = BK_EMIT;
      BK_EMIT:  if (out_free) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    emit        = 1'b0;
    stat_o.busy = 1'b1;
    unique case (state_q)
      BK_IDLE: begin
        pop_o       = !empty_i;
        stat_o.busy = 1'b0;
      end
      BK_EMIT: emit = out_free;
      default: ;
    endcase
    stat_o.emit = emit;
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      fprod[i] = 40'(rec_q.crd[i].frac) * 40'(pow10(FD - rec_q.crd[i].fcount));
      qe100[i] = pd_q[i][PD_W-1:24];
      r100[i]  = 18'(rec_q.crd[i].ipart) - 18'(qe100[i]) * 18'd100;
      qe60[i]  = p_q[i][P_W-1:32];
      r60[i]   = 28'(x_q[i]) - 28'(qe60[i]) * 28'd60;
      q60[i]   = (r60[i] >= 28'd60) ? (qe60[i] + 22'd1) : qe60[i];
      micro[i] = MICRO_W'(degm_q[i]) + MICRO_W'(q60[i]);
    end
    msat[0] = (micro[0] > LAT_LIM) ? LAT_LIM : micro[0];
    msat[1] = (micro[1] > LON_LIM) ? LON_LIM : micro[1];
    for (int i = 0; i < 2; i++) begin
      sval[i] = rec_q.hemi[i] ? (LON_W'(0) - LON_W'(msat[i])) : LON_W'(msat[i]);
    end
  end

  always_comb begin
    t_h  = 7'(rec_q.tdig[0]) * 7'd10 + 7'(rec_q.tdig[1]);
    t_m  = 7'(rec_q.tdig[2]) * 7'd10 + 7'(rec_q.tdig[3]);
    t_s  = 7'(rec_q.tdig[4]) * 7'd10 + 7'(rec_q.tdig[5]);
    d_d  = 7'(rec_q.ddig[0]) * 7'd10 + 7'(rec_q.ddig[1]);
    d_mo = 7'(rec_q.ddig[2]) * 7'd10 + 7'(rec_q.ddig[3]);
    d_yy = 7'(rec_q.ddig[4]) * 7'd10 + 7'(rec_q.ddig[5]);
    n_h  = hh_q;
    n_m  = hm_q;
    n_s  = hs_q;
    n_d  = hd_q;
    n_mo = hmo_q;
    n_yy = hyy_q;
    if (rec_q.time_ok) begin
      n_h = (t_h > 7'd23) ? 5'd23 : t_h[4:0];
      n_m = (t_m > 7'd59) ? 6'd59 : t_m[5:0];
      n_s = (t_s > 7'd59) ? 6'd59 : t_s[5:0];
    end
    if (rec_q.status && rec_q.date_ok) begin
      n_d  = (d_d > 7'd31) ? 6'd31 : d_d[5:0];
      n_mo = (d_mo > 7'd12) ? 4'd12 : d_mo[3:0];
      n_yy = d_yy;
    end
    zh   = (zone_hours_i > 5'd23) ? 5'd23 : zone_hours_i;
    zm   = (zone_minutes_i > 6'd59) ? 6'd59 : zone_minutes_i;
    hsum = 6'(n_h);
    msum = 7'(n_m);
    dsum = n_d;
    if (rec_q.status) begin
      hsum = 6'(n_h) + 6'(zh);
      msum = 7'(n_m) + 7'(zm);
      if (msum >= 7'd60) begin
        msum = msum - 7'd60;
        hsum = hsum + 6'd1;
      end
      if (hsum >= 6'd24) begin
        hsum = hsum - 6'd24;
        dsum = n_d + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          rec_q <= rec_i;
        end
      end
      BK_DIV: begin
        for (int i = 0; i < 2; i++) begin
          pd_q[i]  <= PD_W'(rec_q.crd[i].ipart) * PD_W'(DIV100_M);
          fsc_q[i] <= fprod[i][FRAC_W-1:0];
        end
      end
      BK_SPLIT: begin
        for (int i = 0; i < 2; i++) begin
          if (r100[i] >= 18'd100) begin
            deg_q[i] <= 10'(qe100[i] + 11'd1);
            mm_q[i]  <= 7'(r100[i] - 18'd100);
          end else begin
            deg_q[i] <= qe100[i][9:0];
            mm_q[i]  <= r100[i][6:0];
          end
        end
      end
      BK_SCALE: begin
        for (int i = 0; i < 2; i++) begin
          x_q[i]    <= X_W'(mm_q[i]) * X_W'(1000000) + X_W'(fsc_q[i]) * X_W'(SCALE_K)
                       + X_W'(30);
          degm_q[i] <= DEGM_W'(deg_q[i]) * DEGM_W'(1000000);
        end
      end
      BK_RECIP: begin
        for (int i = 0; i < 2; i++) begin
          p_q[i] <= P_W'(x_q[i]) * P_W'(DIV60_M);
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          out_q.fix_valid <= rec_q.status;
          out_q.hour      <= hsum[4:0];
          out_q.minute    <= msum[5:0];
          out_q.second    <= n_s;
          out_q.day       <= dsum;
          out_q.month     <= n_mo;
          out_q.year      <= YEAR_BASE + 12'(n_yy);
          if (rec_q.status) begin
            out_q.latitude  <= sval[0][LAT_W-1:0];
            out_q.longitude <= sval[1];
          end else begin
            out_q.latitude  <= hlat_q;
            out_q.longitude <= hlon_q;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      hh_q        <= '0;
      hm_q        <= '0;
      hs_q        <= '0;
      hd_q        <= '0;
      hmo_q       <= '0;
      hyy_q       <= '0;
      hlat_q      <= '0;
      hlon_q      <= '0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
        hh_q        <= n_h;
        hm_q        <= n_m;
        hs_q        <= n_s;
        hd_q        <= n_d;
        hmo_q       <= n_mo;
        hyy_q       <= n_yy;
        if (rec_q.status) begin
          hlat_q <= sval[0][LAT_W-1:0];
          hlon_q <= sval[1];
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/nmea_rmc_sentence_parser_unit.sv]
// RMC sentence parser top level: configuration registers, front end, queue, back end.
//
// Usage: received bytes enter on the s_axis channel, one byte per transfer; a
// line ends at byte 0x0A. Each line that starts with "$GPRMC" yields one result
// transfer on the m_axis channel when its newline arrives; other lines yield
// nothing. Fields are taken by position; the checksum is not checked.
// Throughput: one byte per cycle while the queue is not full. Each RMC line
// is handed to the back end through a two-entry queue; the back end takes each
// line through one load step, four fixed coordinate steps and one emit step,
// which registers the result when m_axis is free. An RMC line has at least
// seven bytes, so s_axis_tready stays high while m_axis is free.
// A stalled receiver holds the result in the output register; the back end
// then waits, the queue fills, and s_axis_tready drops once two lines wait.
// Reset clears the line state, the held time, date and position (giving
// 00:00:00, day 0, month 0, year 2000, position 0) and loads zone offset
// 5 h 30 min. Write zone registers through cfg_* only while idle.
`default_nettype none
module nmea_rmc_sentence_parser_unit
  import rmcp_pkg::*;
#(
  parameter int LINE_LIMIT      = 128,
  parameter int FRACTION_DIGITS = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [7:0]       s_axis_tdata_i,   // [7:0] rx_byte
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // [0] fix_valid, [5:1] hour, [11:6] minute, [17:12] second, [23:18] day,
  // [27:24] month, [39:28] year, [67:40] latitude, [96:68] longitude, zero pad
  output logic [RES_W-1:0] m_axis_tdata_o,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [5:0]       cfg_data_i
);

  logic [4:0] zone_hours_q;
  logic [5:0] zone_minutes_q;

  fifo_wr_t    fwr;
  line_rec_t   frec;
  logic        fifo_empty, fifo_full, fifo_pop;
  rmc_result_t res;
  bk_status_t  bk_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_hours_q   <= ZONE_HOURS_RST;
      zone_minutes_q <= ZONE_MINUTES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ZONE_HOURS:   zone_hours_q   <= cfg_data_i[4:0];
        CFG_ZONE_MINUTES: zone_minutes_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rmcp_front #(
    .LINE_LIMIT      (LINE_LIMIT),
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid_i),
    .byte_i       (s_axis_tdata_i),
    .byte_ready_o (s_axis_tready_o),
    .full_i       (fifo_full),
    .wr_o         (fwr)
  );

  rmcp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (fwr),
    .pop_i   (fifo_pop),
    .rec_o   (frec),
    .empty_o (fifo_empty),
    .full_o  (fifo_full)
  );

  rmcp_back #(
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .zone_hours_i   (zone_hours_q),
    .zone_minutes_i (zone_minutes_q),
    .empty_i        (fifo_empty),
    .rec_i          (frec),
    .pop_o          (fifo_pop),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .out_o          (res),
    .stat_o         (bk_stat)
  );

  assign m_axis_tdata_o = {7'd0, res.longitude, res.latitude, res.year, res.month, res.day,
                           res.second, res.minute, res.hour, res.fix_valid};

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_full |-> !fwr.push)
    else $error("queue written while full");

  a_push_on_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwr.push |-> (s_axis_tvalid_i && s_axis_tdata_i == CH_LF))
    else $error("record queued without a newline transfer");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(bk_stat.emit))
    else $error("result shown without an emit step");

  a_pop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> (!fifo_empty && !bk_stat.busy))
    else $error("queue popped while back end busy or queue empty");

endmodule
`default_nettype wire

[dv/rmc_result_checker.sv]
// Checker for the RMC sentence parser: predicts results from byte transfers and compares.
module rmc_result_checker
  import rmcp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  input  logic             s_axis_tready_i,
  input  logic [7:0]       s_axis_tdata_i,
  input  logic             m_axis_tvalid_i,
  input  logic             m_axis_tready_i,
  input  logic [RES_W-1:0] m_axis_tdata_i,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [5:0]       cfg_data_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN = 128;
  localparam int FDIG = 5;

  typedef struct {
    longint unsigned ip;
    longint unsigned fr;
    int unsigned fc;
    bit dot;
    bit stop;
  } crd_acc_t;

  rmc_result_t expected_fixes[$];
  logic [4:0] zone_h;
  logic [5:0] zone_m;
  int unsigned ln_cnt, fld, fch, hdr_prog;
  bit hdr_ok, active, t_ok, d_ok;
  int unsigned tdig, ddig, hemi;
  crd_acc_t lat_a, lon_a;
  int unsigned held_h, held_m, held_s, held_d, held_mo, held_yy;
  logic [LAT_W-1:0] held_lat;
  logic [LON_W-1:0] held_lon;

  assign pending_o = expected_fixes.size();

  function automatic int unsigned clip(int unsigned v, int unsigned hi);
    return v > hi ? hi : v;
  endfunction

  function automatic int unsigned digit_val(logic [7:0] c);
    return (c >= "0" && c <= "9") ? c - "0" : 0;
  endfunction

  function automatic void crd_push(ref crd_acc_t a, input logic [7:0] c);
    if (a.stop) return;
    if (c >= "0" && c <= "9") begin
      if (!a.dot) begin
        a.ip = a.ip * 10 + (c - "0");
        if (a.ip > 99999) a.ip = 99999;
      end else if (a.fc < FDIG) begin
        a.fr = a.fr * 10 + (c - "0");
        a.fc++;
      end
    end else if (c == "." && !a.dot) a.dot = 1;
    else a.stop = 1;
  endfunction

  function automatic longint unsigned micro_deg(crd_acc_t a, bit neg, longint unsigned lim);
    longint unsigned scale, pad, v, deg, mins, mu;
    scale = 100000;
    pad = 1;
    for (int i = a.fc; i < FDIG; i++) pad *= 10;
    v = a.ip * scale + a.fr * pad;
    deg = a.ip / 100;
    mins = v - deg * 100 * scale;
    mu = deg * 1000000 + (mins * 1000000 + 30 * scale) / (60 * scale);
    if (mu > lim) mu = lim;
    return neg ? 64'd0 - mu : mu;
  endfunction

  function automatic void clear_line();
    ln_cnt = 0; fld = 0; fch = 0; hdr_prog = 0;
    hdr_ok = 0; active = 0; t_ok = 0; d_ok = 0;
    tdig = 0; ddig = 0; hemi = 0;
    lat_a = '{0, 0, 0, 0, 0};
    lon_a = '{0, 0, 0, 0, 0};
  endfunction

  function automatic void close_field();
    if (fld == 1) t_ok = fch >= 6;
    if (fld == 9) d_ok = fch == 6;
  endfunction

  function automatic void take_byte(logic [7:0] c);
    rmc_result_t r;
    int unsigned h, m, d;
    if (c != CH_LF) begin
      if (ln_cnt >= MAX_LEN - 1) return;
      if (ln_cnt < 6 && hdr_prog == ln_cnt && c == hdr_char(3'(ln_cnt))) begin
        hdr_prog++;
        if (hdr_prog == 6) hdr_ok = 1;
      end
      ln_cnt++;
      if (c == CH_COMMA) begin
        close_field();
        if (fld < 15) fld++;
        fch = 0;
        return;
      end
      case (fld)
        1: if (fch < 6) tdig = tdig * 10 + digit_val(c);
        2: if (fch == 0) active = (c == CH_A);
        3: crd_push(lat_a, c);
        4: if (fch == 0 && c == CH_S) hemi |= 1;
        5: crd_push(lon_a, c);
        6: if (fch == 0 && c == CH_W) hemi |= 2;
        9: if (fch < 6) ddig = ddig * 10 + digit_val(c);
        default: ;
      endcase
      if (fch < 15) fch++;
      return;
    end
    close_field();
    if (!hdr_ok) begin
      clear_line();
      return;
    end
    if (t_ok) begin
      held_h = clip(tdig / 10000, 23);
      held_m = clip((tdig / 100) % 100, 59);
      held_s = clip(tdig % 100, 59);
    end
    if (active) begin
      if (d_ok) begin
        held_d = clip(ddig / 10000, 31);
        held_mo = clip((ddig / 100) % 100, 12);
        held_yy = ddig % 100;
      end
      held_lat = LAT_W'(micro_deg(lat_a, hemi[0], 90000000));
      held_lon = LON_W'(micro_deg(lon_a, hemi[1], 180000000));
    end
    h = held_h; m = held_m; d = held_d;
    if (active) begin
      h += clip(zone_h, 23);
      m += clip(zone_m, 59);
      if (m >= 60) begin m -= 60; h++; end
      if (h >= 24) begin h -= 24; d++; end
    end
    r.fix_valid = active;
    r.hour = 5'(h);
    r.minute = 6'(m);
    r.second = 6'(held_s);
    r.day = 6'(d);
    r.month = 4'(held_mo);
    r.year = 12'(2000 + held_yy);
    r.latitude = held_lat;
    r.longitude = held_lon;
    expected_fixes.push_back(r);
    clear_line();
  endfunction

  task automatic cmp(string name, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rmc_result_t got, exp_r;
    if (!rst_ni) begin
      zone_h = ZONE_HOURS_RST;
      zone_m = ZONE_MINUTES_RST;
      clear_line();
      held_h = 0; held_m = 0; held_s = 0; held_d = 0; held_mo = 0; held_yy = 0;
      held_lat = '0; held_lon = '0;
      expected_fixes.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ZONE_HOURS) zone_h = cfg_data_i[4:0];
        else zone_m = cfg_data_i;
      end
      if (s_axis_tvalid_i && s_axis_tready_i) take_byte(s_axis_tdata_i);
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.fix_valid = m_axis_tdata_i[0];
        got.hour = m_axis_tdata_i[5:1];
        got.minute = m_axis_tdata_i[11:6];
        got.second = m_axis_tdata_i[17:12];
        got.day = m_axis_tdata_i[23:18];
        got.month = m_axis_tdata_i[27:24];
        got.year = m_axis_tdata_i[39:28];
        got.latitude = m_axis_tdata_i[67:40];
        got.longitude = m_axis_tdata_i[96:68];
        if (expected_fixes.size() == 0) begin
          $error("unexpected result transfer");
          fail_count_o++;
        end else begin
          exp_r = expected_fixes.pop_front();
          cmp("fix_valid", exp_r.fix_valid, got.fix_valid);
          cmp("hour", exp_r.hour, got.hour);
          cmp("minute", exp_r.minute, got.minute);
          cmp("second", exp_r.second, got.second);
          cmp("day", exp_r.day, got.day);
          cmp("month", exp_r.month, got.month);
          cmp("year", exp_r.year, got.year);
          cmp("latitude", exp_r.latitude, got.latitude);
          cmp("longitude", exp_r.longitude, got.longitude);
        end
      end
    end
  end
endmodule

[dv/tb_nmea_rmc_sentence_parser_unit.sv]
// Testbench top for the RMC sentence parser: byte stimulus, idling phases and verdict.
module tb_nmea_rmc_sentence_parser_unit;
  import rmcp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk_i = 0;
  logic             rst_ni = 0;
  logic             s_axis_tvalid_i = 0;
  logic             s_axis_tready_o;
  logic [7:0]       s_axis_tdata_i = '0;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 0;
  logic [RES_W-1:0] m_axis_tdata_o;
  logic             cfg_we_i = 0;
  logic [0:0]       cfg_idx_i = '0;
  logic [5:0]       cfg_data_i = '0;
  int               fail_count, pending;
  int               tx_idle_pct = 0, rx_stall_pct = 0;
  int               sent_bytes = 0;

  nmea_rmc_sentence_parser_unit i_dut (.*);

  rmc_result_checker i_chk (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic send_byte(logic [7:0] b);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sent_bytes++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic write_zone(logic [0:0] idx, logic [5:0] v);
    s_axis_tvalid_i <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  function automatic string num_text(int digits, int maxv);
    string s = "";
    for (int i = 0; i < digits; i++) s = {s, string'(8'("0" + $urandom_range(maxv)))};
    return s;
  endfunction

  function automatic string rand_coord();
    string s;
    int r = $urandom_range(9);
    if (r == 0) return "";
    s = num_text($urandom_range(1, 6), 9);
    if (r > 2) s = {s, ".", num_text($urandom_range(0, 7), 9)};
    if (r == 9) s = {s, ".5-1"};
    return s;
  endfunction

  function automatic string rand_field(string normal);
    string s = "";
    if ($urandom_range(9) != 0) return normal;
    repeat ($urandom_range(0, 8)) s = {s, string'(8'($urandom_range(32, 126)))};
    return s;
  endfunction

  task automatic send_rand_line();
    string s;
    int r = $urandom_range(99);
    if (r < 8) begin
      repeat ($urandom_range(1, 40)) begin
        logic [7:0] b = 8'($urandom_range(255));
        if (b == CH_LF) b = 8'h00;
        s = {s, string'(b)};
      end
    end else begin
      s = (r < 12) ? "$GPGGA" : "$GPRMC";
      s = {s, ",", rand_field({num_text(6, 9), $urandom_range(1) ? ".00" : ""}),
           ",", rand_field($urandom_range(3) ? "A" : "V"),
           ",", rand_field(rand_coord()), ",", rand_field($urandom_range(1) ? "S" : "N"),
           ",", rand_field(rand_coord()), ",", rand_field($urandom_range(1) ? "W" : "E"),
           ",0.5,54.7,", rand_field(num_text(6, 9)), ",,"};
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(0, 12)) s = {s, ",x"};
      s = {s, "*6A\r"};
      if ($urandom_range(29) == 0)
        repeat ($urandom_range(60, 140)) s = {s, string'(8'($urandom_range(0, 9) + "0"))};
    end
    send_text(s);
    send_byte(CH_LF);
  endtask

  initial begin
    int phase;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\n");
    send_text("$GPRMC,235959,A,9999999.99999,S,99999.9,W,,,311299,,\n");
    send_text("$GPRMC,999999,V,1234.5,N,12345.6,E,,,999999\n");
    send_text("$GPRMC,12,A,,,,,,,1234567\n");
    send_byte(8'hFF); send_byte(8'h00);
    send_text("x$GPRMC,000000,A\n");
    write_zone(CFG_ZONE_HOURS, 6'd31);
    write_zone(CFG_ZONE_MINUTES, 6'd63);
    send_text("$GPRMC,2359ab,A,0000.0,S,18000.00001,W,,,000000\n");
    write_zone(CFG_ZONE_HOURS, 6'd0);
    write_zone(CFG_ZONE_MINUTES, 6'd0);
    send_text("$GPRMC,000000,A,12.3.4,N,1.+5,E,,,010100\n");
    while (sent_bytes < 1900) begin
      phase = sent_bytes * 4 / 1900;
      tx_idle_pct = (phase == 1) ? 52 : (phase == 3) ? 33 : 0;
      rx_stall_pct = (phase == 2) ? 52 : (phase == 3) ? 33 : 0;
      if ($urandom_range(39) == 0) begin
        tx_idle_pct = 0;
        write_zone(CFG_ZONE_HOURS, 6'($urandom_range(0, 31)));
        write_zone(CFG_ZONE_MINUTES, 6'($urandom_range(0, 63)));
      end
      send_rand_line();
    end
    s_axis_tvalid_i <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
